FILE: hw/rtl/m93_pkg.sv
// shared types, codes and helpers for the microwire eeprom mapper
`timescale 1ns / 1ps

package m93_pkg;

   localparam int WORD_COUNT = 64;
   localparam int INDEX_WIDTH = $clog2(WORD_COUNT);

   localparam logic [15:0] DIRECT_BASE = 16'h8008;
   localparam logic [15:0] ERASED_WORD = 16'hffff;

   // access kinds
   localparam logic [2:0] KIND_CTRL_WR   = 3'd0;
   localparam logic [2:0] KIND_LINE_WR   = 3'd1;
   localparam logic [2:0] KIND_LINE_RD   = 3'd2;
   localparam logic [2:0] KIND_CTRL_RD   = 3'd3;
   localparam logic [2:0] KIND_DIRECT_RD = 3'd4;
   localparam logic [2:0] KIND_DIRECT_WR = 3'd5;

   // command opcodes and the sub codes of opcode zero
   localparam logic [1:0] OP_MISC  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;
   localparam logic [1:0] SUB_EWDS = 2'd0;
   localparam logic [1:0] SUB_ERAL = 2'd2;
   localparam logic [1:0] SUB_EWEN = 2'd3;

   localparam logic [4:0] CMD_BITS_DONE  = 5'd9;
   localparam logic [4:0] DATA_BITS_DONE = 5'd16;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  wdata;
      logic [15:0] addr;
   } req_type_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       save_pulse;
   } rsp_type;

   // store write request from the protocol logic
   typedef struct packed {
      logic                   wr_en;
      logic                   clear_all;
      logic [INDEX_WIDTH-1:0] addr;
      logic [15:0]            data;
   } mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [15:0] direct_offset(input logic [15:0] addr);
      return addr - DIRECT_BASE;
   endfunction

   // word index a request needs from the store
   function automatic logic [INDEX_WIDTH-1:0] read_index(input req_type_type req,
                                                         input logic [15:0] shift);
      logic [15:0] offs;
      offs = direct_offset(req.addr);
      if (req.req_type == KIND_DIRECT_RD || req.req_type == KIND_DIRECT_WR) begin
         return offs[INDEX_WIDTH:1];
      end
      // a line write that completes a command addresses with its low bits
      return {shift[INDEX_WIDTH-2:0], req.wdata[0]};
   endfunction

endpackage

FILE: hw/rtl/m93_store.sv
// 64x16 word store with registered read and per-word valid bits
`timescale 1ns / 1ps

module m93_store
   import m93_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [INDEX_WIDTH-1:0] rd_addr,
   output logic [15:0]            rd_data,
   input  mem_req_type            mem_req
);

   logic [15:0]           mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_COUNT-1:0] valid_in;
   logic [15:0]           rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // words never written since reset or a full erase read as erased
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.clear_all) begin
         valid_in = '0;
      end else if (mem_req.wr_en) begin
         valid_in[mem_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : ERASED_WORD;

endmodule

FILE: hw/rtl/m93_proto.sv
// microwire protocol state and per-access decode
`timescale 1ns / 1ps

module m93_proto
   import m93_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_type_type req,
   input  logic [15:0]  rd_word,
   output logic [15:0]  shift_out,
   output rsp_type      result,
   output mem_req_type  mem_req
);

   logic        port_en_ff, port_en_in;
   logic        wel_ff, wel_in;
   logic [2:0]  line_ff, line_in;
   logic        reading_ff, reading_in;
   logic [7:0]  pend_ff, pend_in;
   logic [15:0] shift_ff, shift_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        dout_ff, dout_in;

   logic [15:0] offs;
   logic        in_range;
   logic        rising;
   logic        cs;
   logic        di;
   logic [15:0] shifted;
   logic [4:0]  cnt_inc;
   logic [7:0]  cmd;

   always_comb begin
      offs     = direct_offset(req.addr);
      in_range = (offs[8:INDEX_WIDTH+1] == '0);
      rising   = !line_ff[1] && req.wdata[1];
      cs       = req.wdata[2];
      di       = req.wdata[0];
      shifted  = {shift_ff[14:0], di};
      cnt_inc  = cnt_ff + 5'd1;
      cmd      = shifted[7:0];

      port_en_in = port_en_ff;
      wel_in     = wel_ff;
      line_in    = line_ff;
      reading_in = reading_ff;
      pend_in    = pend_ff;
      shift_in   = shift_ff;
      cnt_in     = cnt_ff;
      dout_in    = dout_ff;

      result  = '0;
      mem_req = '0;

      case (req.req_type)
         KIND_CTRL_WR: begin
            if (req.wdata[7]) begin
               wel_in     = 1'b0;
               line_in    = '0;
               reading_in = 1'b0;
               pend_in    = '0;
               shift_in   = '0;
               cnt_in     = '0;
               dout_in    = 1'b1;
            end
            port_en_in = req.wdata[3];
         end
         KIND_LINE_WR: begin
            line_in = req.wdata[2:0];
            if (port_en_ff) begin
               if (!cs) begin
                  cnt_in     = '0;
                  pend_in    = '0;
                  reading_in = 1'b0;
                  shift_in   = '0;
                  dout_in    = 1'b1;
               end else if (rising) begin
                  if (reading_ff) begin
                     shift_in = {shift_ff[14:0], 1'b0};
                     cnt_in   = cnt_inc;
                     dout_in  = shift_ff[14];
                  end else if (pend_ff[7:6] == OP_WRITE) begin
                     shift_in = shifted;
                     cnt_in   = cnt_inc;
                     if (cnt_inc == DATA_BITS_DONE) begin
                        if (wel_ff) begin
                           mem_req.wr_en     = 1'b1;
                           mem_req.addr      = pend_ff[INDEX_WIDTH-1:0];
                           mem_req.data      = shifted;
                           result.save_pulse = 1'b1;
                        end
                        pend_in  = '0;
                        cnt_in   = '0;
                        shift_in = '0;
                     end
                  end else if (cnt_ff == '0) begin
                     // waiting for the start bit
                     if (di) begin
                        cnt_in   = 5'd1;
                        shift_in = '0;
                     end
                  end else begin
                     shift_in = shifted;
                     cnt_in   = cnt_inc;
                     if (cnt_inc == CMD_BITS_DONE) begin
                        cnt_in     = '0;
                        shift_in   = '0;
                        reading_in = 1'b0;
                        case (cmd[7:6])
                           OP_MISC: begin
                              if (cmd[5:4] == SUB_EWDS) begin
                                 wel_in = 1'b0;
                              end else if (cmd[5:4] == SUB_EWEN) begin
                                 wel_in = 1'b1;
                              end else if (cmd[5:4] == SUB_ERAL && wel_ff) begin
                                 mem_req.clear_all = 1'b1;
                                 result.save_pulse = 1'b1;
                              end
                           end
                           OP_WRITE: begin
                              pend_in = cmd;
                           end
                           OP_READ: begin
                              shift_in   = rd_word;
                              reading_in = 1'b1;
                              dout_in    = rd_word[15];
                           end
                           OP_ERASE: begin
                              if (wel_ff) begin
                                 mem_req.wr_en     = 1'b1;
                                 mem_req.addr      = cmd[INDEX_WIDTH-1:0];
                                 mem_req.data      = ERASED_WORD;
                                 result.save_pulse = 1'b1;
                              end
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
               end
            end
         end
         KIND_LINE_RD: begin
            result.rdata = port_en_ff ? {5'b0, line_ff[2:1], dout_ff} : 8'hff;
         end
         KIND_CTRL_RD: begin
            result.rdata = {4'b0, port_en_ff, 3'b0};
         end
         KIND_DIRECT_RD: begin
            if (!in_range) begin
               result.rdata = 8'hff;
            end else if (offs[0]) begin
               result.rdata = rd_word[15:8];
            end else begin
               result.rdata = rd_word[7:0];
            end
         end
         KIND_DIRECT_WR: begin
            if (in_range) begin
               mem_req.wr_en     = 1'b1;
               mem_req.addr      = offs[INDEX_WIDTH:1];
               mem_req.data      = offs[0] ? {req.wdata, rd_word[7:0]}
                                           : {rd_word[15:8], req.wdata};
               result.save_pulse = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // nothing reaches the store unless the access is committed
      if (!step) begin
         mem_req = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_en_ff <= 1'b0;
         wel_ff     <= 1'b0;
         line_ff    <= '0;
         reading_ff <= 1'b0;
         pend_ff    <= '0;
         shift_ff   <= '0;
         cnt_ff     <= '0;
         dout_ff    <= 1'b1;
      end else if (step) begin
         port_en_ff <= port_en_in;
         wel_ff     <= wel_in;
         line_ff    <= line_in;
         reading_ff <= reading_in;
         pend_ff    <= pend_in;
         shift_ff   <= shift_in;
         cnt_ff     <= cnt_in;
         dout_ff    <= dout_in;
      end
   end

   assign shift_out = shift_ff;

endmodule

FILE: hw/rtl/microwire_eeprom_93c46_mapper_core.sv
// top level of the microwire eeprom mapper: sequencer, store and result register
`timescale 1ns / 1ps

// 93c46-style 64x16 serial eeprom reached through a bit-banged port.
// req channel: one port access per transfer (control write/read, line
// write/read, direct byte read/write at offsets from 0x8008).
// rsp channel: one result per access, the byte read and a save pulse that
// marks an access that wrote the word store.
// each access runs in order: the request is registered, the store is read
// (synchronous memory), then the access is decoded, the store written back
// and the result loaded into the output register.
// rsp_valid rises once the commit step has loaded the output register; a new
// request is taken only after the current access has been committed.
// a full erase clears all per-word valid bits at once, no sweep.
// reset clears the protocol state and the valid bits, so every word reads
// 0xffff right after reset with no clearing pass.
// when the receiver stalls, the result waits in the output register; the
// block still takes one more request and holds it in its last step until
// the output register frees up.

module microwire_eeprom_93c46_mapper_core
   import m93_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   state_type    state_ff, state_in;
   req_type_type req_ff;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic                   step;
   logic                   rd_en;
   logic [INDEX_WIDTH-1:0] rd_addr;
   logic [15:0]            rd_word;
   logic [15:0]            shift;
   rsp_type                result;
   mem_req_type            mem_req;

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_en     = (state_ff == ST_READ);
   assign rd_addr   = read_index(req_ff, shift);
   // commit only when the output register can take the result
   assign step      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   m93_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word),
      .mem_req (mem_req)
   );

   m93_proto u_proto (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_ff),
      .rd_word   (rd_word),
      .shift_out (shift),
      .result    (result),
      .mem_req   (mem_req)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_reads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted request did not start a store read");

   a_read_then_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_DONE))
      else $error("store read not followed by the commit step");

   a_write_on_step : assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en || mem_req.clear_all) |-> step)
      else $error("store written outside the commit step");

   a_save_has_write : assert property (@(posedge clock) disable iff (reset)
      (step && result.save_pulse) |-> (mem_req.wr_en || mem_req.clear_all))
      else $error("save pulse without a store write");

   a_step_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("committed access left no result");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the microwire eeprom mapper core
`timescale 1ns / 1ps

module testbench;
   import m93_pkg::*;

   localparam logic [2:0] KIND_NONE_6 = 3'd6;
   localparam logic [2:0] KIND_NONE_7 = 3'd7;
   localparam logic [1:0] SUB_WRAL    = 2'd1;

   localparam logic [7:0] CTRL_RESET  = 8'h80;
   localparam logic [7:0] CTRL_ENABLE = 8'h08;
   localparam int CTRL_RESET_BIT  = 7;
   localparam int CTRL_ENABLE_BIT = 3;

   localparam logic [7:0] LINE_DI  = 8'h01;
   localparam logic [7:0] LINE_SCK = 8'h02;
   localparam logic [7:0] LINE_CS  = 8'h04;
   localparam int LINE_SCK_BIT = 1;
   localparam int LINE_CS_BIT  = 2;

   localparam int DIRECTED_ROWS   = 25;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct {
      req_type_type req;
      logic         typed;
      rsp_type      rsp;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;

   // mirror of the eeprom and its protocol state
   logic [15:0] mirror_words [WORD_COUNT];
   logic        mir_enabled = 1'b0;
   logic        mir_wen = 1'b0;
   logic [2:0]  mir_lines = 3'd0;
   logic        mir_reading = 1'b0;
   logic [7:0]  mir_cmd = 8'd0;
   logic [15:0] mir_shift = 16'd0;
   logic [4:0]  mir_count = 5'd0;
   logic        mir_dout = 1'b1;

   rsp_type     access_results_q [$];
   int          error_count = 0;
   int          items_sent = 0;
   int unsigned snd_idle_pct;
   int unsigned rcv_idle_pct;
   int          rsp_hold_cycles = 0;

   microwire_eeprom_93c46_mapper_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type predict_access(input req_type_type r);
      rsp_type     res;
      logic [15:0] offs;
      logic [7:0]  word;
      logic [7:0]  v;
      logic [7:0]  cmd;
      logic        rising;
      res = '0;
      offs = r.addr - DIRECT_BASE;
      word = offs[8:1];
      v = r.wdata;
      case (r.req_type)
         KIND_CTRL_WR: begin
            if (v[CTRL_RESET_BIT]) begin
               mir_wen = 1'b0;
               mir_lines = 3'd0;
               mir_reading = 1'b0;
               mir_cmd = 8'd0;
               mir_shift = 16'd0;
               mir_count = 5'd0;
               mir_dout = 1'b1;
            end
            mir_enabled = v[CTRL_ENABLE_BIT];
         end
         KIND_LINE_WR: begin
            rising = !mir_lines[LINE_SCK_BIT] && v[LINE_SCK_BIT];
            mir_lines = v[2:0];
            if (!mir_enabled) begin
               // disabled port only latches the lines
            end else if (!v[LINE_CS_BIT]) begin
               mir_count = 5'd0;
               mir_cmd = 8'd0;
               mir_reading = 1'b0;
               mir_shift = 16'd0;
               mir_dout = 1'b1;
            end else if (rising) begin
               if (mir_reading) begin
                  mir_shift = mir_shift << 1;
                  mir_count = mir_count + 5'd1;
                  mir_dout = mir_shift[15];
               end else if (mir_cmd[7:6] == OP_WRITE) begin
                  mir_shift = {mir_shift[14:0], v[0]};
                  mir_count = mir_count + 5'd1;
                  if (mir_count == DATA_BITS_DONE) begin
                     if (mir_wen) begin
                        mirror_words[mir_cmd[5:0]] = mir_shift;
                        res.save_pulse = 1'b1;
                     end
                     mir_cmd = 8'd0;
                     mir_count = 5'd0;
                     mir_shift = 16'd0;
                  end
               end else if (mir_count == 5'd0) begin
                  // waiting for the start bit
                  if (v[0]) begin
                     mir_count = 5'd1;
                     mir_shift = 16'd0;
                  end
               end else begin
                  mir_shift = {mir_shift[14:0], v[0]};
                  mir_count = mir_count + 5'd1;
                  if (mir_count == CMD_BITS_DONE) begin
                     cmd = mir_shift[7:0];
                     mir_count = 5'd0;
                     mir_shift = 16'd0;
                     mir_reading = 1'b0;
                     case (cmd[7:6])
                        OP_MISC: begin
                           if (cmd[5:4] == SUB_EWDS) begin
                              mir_wen = 1'b0;
                           end else if (cmd[5:4] == SUB_EWEN) begin
                              mir_wen = 1'b1;
                           end else if (cmd[5:4] == SUB_ERAL && mir_wen) begin
                              foreach (mirror_words[i]) mirror_words[i] = ERASED_WORD;
                              res.save_pulse = 1'b1;
                           end
                        end
                        OP_WRITE: begin
                           mir_cmd = cmd;
                        end
                        OP_READ: begin
                           mir_shift = mirror_words[cmd[5:0]];
                           mir_reading = 1'b1;
                           mir_dout = mir_shift[15];
                        end
                        OP_ERASE: begin
                           if (mir_wen) begin
                              mirror_words[cmd[5:0]] = ERASED_WORD;
                              res.save_pulse = 1'b1;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         end
         KIND_LINE_RD: begin
            res.rdata = mir_enabled ? {5'd0, mir_lines[2:1], mir_dout} : 8'hff;
         end
         KIND_CTRL_RD: begin
            res.rdata = mir_enabled ? CTRL_ENABLE : 8'h00;
         end
         KIND_DIRECT_RD: begin
            if (word >= WORD_COUNT) begin
               res.rdata = 8'hff;
            end else if (offs[0]) begin
               res.rdata = mirror_words[word[5:0]][15:8];
            end else begin
               res.rdata = mirror_words[word[5:0]][7:0];
            end
         end
         KIND_DIRECT_WR: begin
            if (word < WORD_COUNT) begin
               if (offs[0]) mirror_words[word[5:0]][15:8] = v;
               else mirror_words[word[5:0]][7:0] = v;
               res.save_pulse = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic req_type_type make_req(input logic [2:0] kind, input logic [7:0] wd,
                                             input logic [15:0] ad);
      req_type_type r;
      r.req_type = kind;
      r.wdata = wd;
      r.addr = ad;
      return r;
   endfunction

   function automatic directed_row_type dir_row(input logic [2:0] kind,
                                                input logic [7:0] wd,
                                                input logic [15:0] ad, input logic typed,
                                                input logic [7:0] rd, input logic sv);
      directed_row_type row;
      row.req = make_req(kind, wd, ad);
      row.typed = typed;
      row.rsp.rdata = rd;
      row.rsp.save_pulse = sv;
      return row;
   endfunction

   // offer one access, wait for its transfer, then queue the expected result
   task automatic send_access(input req_type_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      predicted = predict_access(r);
      access_results_q.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic send_line(input logic [7:0] v);
      send_access(make_req(KIND_LINE_WR, v, 16'($urandom)), 1'b0, '0);
   endtask

   task automatic clock_bit(input logic di, input logic peek);
      send_line(LINE_CS | (di ? LINE_DI : 8'h00));
      send_line(LINE_CS | LINE_SCK | (di ? LINE_DI : 8'h00));
      if (peek) send_access(make_req(KIND_LINE_RD, 8'($urandom), 16'($urandom)), 1'b0, '0);
   endtask

   // one framed microwire command with random content, now and then cut short
   task automatic run_command_sequence();
      logic [7:0]  cmd;
      logic [15:0] data;
      logic [5:0]  word_idx;
      logic [8:0]  head;
      logic [7:0]  ctrl;
      logic        di;
      int          pick;
      int          nbits;
      int          abort_at;
      int          i;
      word_idx = ($urandom_range(0, 3) == 0) ? 6'd63 : 6'($urandom_range(0, 63));
      data = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = {OP_MISC, SUB_EWEN, 4'($urandom)};
      else if (pick < 45) cmd = {OP_WRITE, word_idx};
      else if (pick < 70) cmd = {OP_READ, word_idx};
      else if (pick < 80) cmd = {OP_ERASE, word_idx};
      else if (pick < 85) cmd = {OP_MISC, SUB_ERAL, 4'($urandom)};
      else if (pick < 93) cmd = {OP_MISC, SUB_EWDS, 4'($urandom)};
      else cmd = {OP_MISC, SUB_WRAL, 4'($urandom)};
      if (!mir_enabled || $urandom_range(0, 15) == 0) begin
         ctrl = ($urandom_range(0, 3) == 0) ? (CTRL_RESET | CTRL_ENABLE) : CTRL_ENABLE;
         send_access(make_req(KIND_CTRL_WR, ctrl, 16'($urandom)), 1'b0, '0);
      end
      send_line(8'h00);
      send_line(LINE_CS);
      repeat ($urandom_range(0, 2)) clock_bit(1'b0, 1'b0);
      head = {1'b1, cmd};
      nbits = 9;
      if (cmd[7:6] == OP_WRITE) nbits = 25;
      else if (cmd[7:6] == OP_READ)
         nbits = ($urandom_range(0, 4) == 0) ? 9 + $urandom_range(17, 40) : 25;
      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nbits - 1) : nbits;
      for (i = 0; i < abort_at; i++) begin
         if (i < 9) di = head[8 - i];
         else if (cmd[7:6] == OP_WRITE) di = data[24 - i];
         else di = 1'($urandom);
         if (cmd[7:6] == OP_READ && i >= 8) clock_bit(di, $urandom_range(0, 1) == 1);
         else clock_bit(di, $urandom_range(0, 7) == 0);
      end
      if (abort_at < nbits && $urandom_range(0, 1) == 0) begin
         send_access(make_req(KIND_CTRL_WR, CTRL_RESET | CTRL_ENABLE, 16'($urandom)), 1'b0, '0);
      end else if (abort_at == nbits && $urandom_range(0, 1) == 0) begin
         // read the word back through the direct window
         send_access(make_req(KIND_DIRECT_RD, 8'($urandom),
                              DIRECT_BASE + {9'd0, word_idx, 1'b0}), 1'b0, '0);
         send_access(make_req(KIND_DIRECT_RD, 8'($urandom),
                              DIRECT_BASE + {9'd0, word_idx, 1'b1}), 1'b0, '0);
      end
      // drop cs with random clk and di
      send_line(8'($urandom_range(0, 3)));
   endtask

   task automatic send_noise();
      logic [15:0] ad;
      logic [7:0]  wd;
      int          pick;
      pick = $urandom_range(0, 9);
      ad = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(DIRECT_BASE + $urandom_range(0, 1023));
      wd = 8'($urandom);
      case (pick)
         0, 1: send_line(wd);
         2: send_access(make_req(KIND_LINE_RD, wd, ad), 1'b0, '0);
         3: send_access(make_req(KIND_CTRL_RD, wd, ad), 1'b0, '0);
         4: begin
            if ($urandom_range(0, 3) != 0) wd = wd | CTRL_ENABLE;
            send_access(make_req(KIND_CTRL_WR, wd, ad), 1'b0, '0);
         end
         5, 6: send_access(make_req(KIND_DIRECT_RD, wd, ad), 1'b0, '0);
         7, 8: send_access(make_req(KIND_DIRECT_WR, wd, ad), 1'b0, '0);
         default: begin
            send_access(make_req($urandom_range(0, 1) ? KIND_NONE_7 : KIND_NONE_6, wd, ad),
                        1'b0, '0);
         end
      endcase
   endtask

   // result receiver, with an optional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // outputs are stable at the falling edge, so the transfer is seen race free
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (access_results_q.size() == 0) begin
            $error("unexpected transfer: rdata %02h save_pulse %0b",
                   rsp_data.rdata, rsp_data.save_pulse);
            error_count++;
         end else begin
            want = access_results_q.pop_front();
            if (rsp_data.rdata !== want.rdata) begin
               $error("rdata: expected %02h actual %02h", want.rdata, rsp_data.rdata);
               error_count++;
            end
            if (rsp_data.save_pulse !== want.save_pulse) begin
               $error("save_pulse: expected %0b actual %0b", want.save_pulse,
                      rsp_data.save_pulse);
               error_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type rows [DIRECTED_ROWS];
      int               rnd_start;
      int               progress;
      logic             pressure_done;
      foreach (mirror_words[i]) mirror_words[i] = ERASED_WORD;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      snd_idle_pct = 25;
      rcv_idle_pct = 84;
      pressure_done = 1'b0;
      rows = '{
         dir_row(KIND_CTRL_RD,   8'h00, 16'h0000, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_LINE_RD,   8'h00, 16'h0000, 1'b1, 8'hff, 1'b0),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h8008, 1'b1, 8'hff, 1'b0),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h8087, 1'b1, 8'hff, 1'b0),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h8088, 1'b1, 8'hff, 1'b0),
         dir_row(KIND_DIRECT_WR, 8'h00, 16'h8008, 1'b1, 8'h00, 1'b1),
         dir_row(KIND_DIRECT_RD, 8'hff, 16'h8008, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_DIRECT_WR, 8'ha5, 16'h8087, 1'b1, 8'h00, 1'b1),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h8087, 1'b1, 8'ha5, 1'b0),
         dir_row(KIND_DIRECT_WR, 8'hff, 16'h8088, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_DIRECT_WR, 8'h00, 16'h8007, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h8208, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_DIRECT_RD, 8'h00, 16'h0000, 1'b1, 8'hff, 1'b0),
         dir_row(KIND_DIRECT_WR, 8'hff, 16'hffff, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_LINE_WR,   8'h07, 16'hffff, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_CTRL_WR,   8'h08, 16'h0000, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_CTRL_RD,   8'h00, 16'h0000, 1'b1, 8'h08, 1'b0),
         dir_row(KIND_LINE_RD,   8'h00, 16'h0000, 1'b0, 8'h00, 1'b0),
         dir_row(KIND_LINE_WR,   8'h00, 16'h0000, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_LINE_RD,   8'hff, 16'hffff, 1'b0, 8'h00, 1'b0),
         dir_row(KIND_NONE_6,    8'hff, 16'hffff, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_NONE_7,    8'hff, 16'hffff, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_CTRL_WR,   8'h80, 16'h0000, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_CTRL_RD,   8'h00, 16'h0000, 1'b1, 8'h00, 1'b0),
         dir_row(KIND_CTRL_WR,   8'hff, 16'h0000, 1'b1, 8'h00, 1'b0)
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_access(rows[i].req, rows[i].typed, rows[i].rsp);

      rnd_start = items_sent;
      progress = 0;
      while (progress < RANDOM_ITEMS) begin
         if (progress < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 25;
            rcv_idle_pct = 84;
         end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 84;
            rcv_idle_pct = 25;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
            // receiver stalls while the sender keeps offering
            if (!pressure_done) begin
               rsp_hold_cycles = HOLD_OFF_CYCLES;
               pressure_done = 1'b1;
            end
         end
         if ($urandom_range(0, 99) < 70) run_command_sequence();
         else repeat ($urandom_range(1, 4)) send_noise();
         progress = items_sent - rnd_start;
      end
      req_valid <= 1'b0;

      while (access_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
